// ===== hw/rtl/ccd_laser_spot_centroid_assert.svh =====
// Assertion macros used by the laser spot centroid datapath.
`ifndef CCD_LASER_SPOT_CENTROID_ASSERT_SVH
`define CCD_LASER_SPOT_CENTROID_ASSERT_SVH

// Checked on every rising edge outside reset.
`define CCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ccd_pkg.sv =====
// Package with the shared types and constants of the laser spot centroid block.
package ccd_pkg;

  localparam int WSUM_W      = 20;
  localparam int ISUM_W      = 23;
  localparam int DVD_W       = 24;
  localparam int DVS_W       = 16;
  localparam int FILL_W      = 5;
  localparam int IDX_W       = 12;
  localparam int MEAN_W      = 8;
  localparam int BVAL_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0]  RST_DARK_MARGIN   = 8'd30;
  localparam logic [11:0] RST_WINDOW_START  = 12'd32;
  localparam logic [11:0] RST_WINDOW_END    = 12'd3647;
  localparam logic [11:0] RST_MEAN_DIVISOR  = 12'd3648;
  localparam logic [4:0]  RST_BATCH_SIZE    = 5'd10;
  localparam logic [7:0]  RST_SCALE_MULT    = 8'd8;
  localparam logic [15:0] RST_SCALE_DIVISOR = 16'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_MARGIN   = 3'd0,
    CFG_WINDOW_START  = 3'd1,
    CFG_WINDOW_END    = 3'd2,
    CFG_MEAN_DIVISOR  = 3'd3,
    CFG_BATCH_SIZE    = 3'd4,
    CFG_SCALE_MULT    = 3'd5,
    CFG_SCALE_DIVISOR = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_SCAN,
    ST_CENT,
    ST_CENT_WAIT,
    ST_BATCH,
    ST_BATCH_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_CENT,
    DIV_BATCH
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     mean_ld;
    logic     scan_step;
    logic     cent_ld;
    logic     cent_clr;
    logic     batch_add;
    logic     batch_ld;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic cnt_zero;
    logic batch_add_ok;
    logic batch_report;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/ccd_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module ccd_div import ccd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quot,
  output logic             busy,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic [DVD_W-1:0] dq_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quot = dq_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/ccd_dp.sv =====
// Datapath: frame memory, sums, scan, batch and output register.
module ccd_dp import ccd_pkg::*; #(
  parameter int FRAME_PIXELS = 3694,
  parameter int MAX_BATCH    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  `include "ccd_laser_spot_centroid_assert.svh"

  localparam int AW    = $clog2(FRAME_PIXELS);
  localparam int POS_W = $clog2(FRAME_PIXELS + 1);

  logic [7:0]  margin_r;
  logic [11:0] win_start_r;
  logic [11:0] win_end_r;
  logic [11:0] mdiv_r;
  logic [4:0]  bsize_r;
  logic [7:0]  smul_r;
  logic [15:0] sdiv_r;

  logic [7:0]        mem [FRAME_PIXELS];
  logic [POS_W-1:0]  pos_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [MEAN_W-1:0] mean_r;
  logic [POS_W-1:0]  addr_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic [7:0]        rdata_r;
  logic [ISUM_W-1:0] isum_r;
  logic [POS_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  cent_r;
  logic [FILL_W-1:0] fill_r;
  logic [BVAL_W-1:0] bsum_r;
  logic              brdy_r;
  logic [BVAL_W-1:0] bval_r;
  logic              bsat_r;
  logic              out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic              pos_lt;
  logic              in_win;
  logic              scan_rd;
  logic              dark;
  logic [FILL_W-1:0] size;
  logic [DVD_W-1:0]  prod;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  div_q;
  logic              div_busy;
  logic              div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r    <= RST_DARK_MARGIN;
      win_start_r <= RST_WINDOW_START;
      win_end_r   <= RST_WINDOW_END;
      mdiv_r      <= RST_MEAN_DIVISOR;
      bsize_r     <= RST_BATCH_SIZE;
      smul_r      <= RST_SCALE_MULT;
      sdiv_r      <= RST_SCALE_DIVISOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DARK_MARGIN:   margin_r    <= cfg_data[7:0];
        CFG_WINDOW_START:  win_start_r <= cfg_data[11:0];
        CFG_WINDOW_END:    win_end_r   <= cfg_data[11:0];
        CFG_MEAN_DIVISOR:  mdiv_r      <= cfg_data[11:0];
        CFG_BATCH_SIZE:    bsize_r     <= cfg_data[4:0];
        CFG_SCALE_MULT:    smul_r      <= cfg_data[7:0];
        CFG_SCALE_DIVISOR: sdiv_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign pos_lt  = pos_r < POS_W'(FRAME_PIXELS);
  assign in_win  = (13'(pos_r) >= 13'(win_start_r)) && (13'(pos_r) <= 13'(win_end_r));
  assign scan_rd = cmd.scan_step && (addr_r < pos_r);
  assign dark    = ({1'b0, rdata_r} + {1'b0, margin_r}) < {1'b0, mean_r};
  assign size    = (bsize_r > FILL_W'(MAX_BATCH)) ? FILL_W'(MAX_BATCH) : bsize_r;
  assign prod    = DVD_W'(bsum_r) * DVD_W'(smul_r);

  always_ff @(posedge clk) begin
    if (cmd.load && pos_lt) begin
      mem[pos_r[AW-1:0]] <= in_tdata;
    end
    if (scan_rd) begin
      rdata_r <= mem[addr_r[AW-1:0]];
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_MEAN: begin
        div_dvd = DVD_W'(wsum_r);
        div_dvs = DVS_W'(mdiv_r);
      end
      DIV_CENT: begin
        div_dvd = DVD_W'(isum_r);
        div_dvs = DVS_W'(cnt_r);
      end
      DIV_BATCH: begin
        div_dvd = prod;
        div_dvs = sdiv_r;
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  ccd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      wsum_r       <= '0;
      rd_vld_r     <= 1'b0;
      addr_r       <= '0;
      cnt_r        <= '0;
      fill_r       <= '0;
      bsum_r       <= '0;
      brdy_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load && pos_lt) begin
        pos_r <= pos_r + POS_W'(1);
        if (in_win) begin
          wsum_r <= wsum_r + WSUM_W'(in_tdata);
        end
      end
      rd_vld_r <= scan_rd;
      if (scan_rd) begin
        addr_r   <= addr_r + POS_W'(1);
        rd_idx_r <= addr_r[AW-1:0];
      end
      if (rd_vld_r && dark) begin
        isum_r <= isum_r + ISUM_W'(rd_idx_r);
        cnt_r  <= cnt_r + POS_W'(1);
      end
      if (cmd.mean_ld) begin
        mean_r <= (|div_q[DVD_W-1:MEAN_W]) ? '1 : div_q[MEAN_W-1:0];
        addr_r <= '0;
        isum_r <= '0;
        cnt_r  <= '0;
        brdy_r <= 1'b0;
        bval_r <= '0;
        bsat_r <= 1'b0;
      end
      if (cmd.cent_ld) begin
        cent_r <= div_q[IDX_W-1:0];
      end
      if (cmd.cent_clr) begin
        cent_r <= '0;
      end
      if (cmd.batch_add) begin
        fill_r <= fill_r + FILL_W'(1);
        bsum_r <= bsum_r + BVAL_W'(cent_r);
      end
      if (cmd.batch_ld) begin
        brdy_r <= 1'b1;
        bsat_r <= |div_q[DVD_W-1:BVAL_W];
        bval_r <= (|div_q[DVD_W-1:BVAL_W]) ? '1 : div_q[BVAL_W-1:0];
        fill_r <= '0;
        bsum_r <= '0;
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {1'b0, bsat_r, bval_r, brdy_r, mean_r, cent_r, (cnt_r != '0)};
        pos_r        <= '0;
        wsum_r       <= '0;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign stat.div_done     = div_done;
  assign stat.scan_done    = (addr_r >= pos_r) && !rd_vld_r;
  assign stat.cnt_zero     = (cnt_r == '0);
  assign stat.batch_add_ok = (fill_r < size) && (cent_r != '0);
  assign stat.batch_report = (fill_r >= size);
  assign stat.out_free     = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `CCD_ASSERT(a_div_idle, cmd.div_start |-> !div_busy, "divider started while busy")
  `CCD_ASSERT(a_pos_bound, pos_r <= POS_W'(FRAME_PIXELS), "pixel position past frame size")
  `CCD_ASSERT(a_fill_bound, fill_r <= FILL_W'(MAX_BATCH), "batch fill past maximum")
  `CCD_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid_r, "output valid after reset")

endmodule

// ===== hw/rtl/ccd_ctrl.sv =====
// Controller state machine sequencing load, mean, scan, centroid and batch steps.
module ccd_ctrl import ccd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid && in_tlast) state_nxt = ST_MEAN;
      end
      ST_MEAN:      state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (stat.div_done) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_CENT;
      end
      ST_CENT: begin
        state_nxt = stat.cnt_zero ? ST_BATCH : ST_CENT_WAIT;
      end
      ST_CENT_WAIT: begin
        if (stat.div_done) state_nxt = ST_BATCH;
      end
      ST_BATCH: begin
        if (!stat.batch_add_ok && stat.batch_report) begin
          state_nxt = ST_BATCH_WAIT;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_BATCH_WAIT: begin
        if (stat.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_MEAN;
    in_tready   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_MEAN: begin
        cmd.div_start = 1'b1;
      end
      ST_MEAN_WAIT: begin
        cmd.mean_ld = stat.div_done;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_CENT: begin
        cmd.div_sel   = DIV_CENT;
        cmd.div_start = !stat.cnt_zero;
        cmd.cent_clr  = stat.cnt_zero;
      end
      ST_CENT_WAIT: begin
        cmd.cent_ld = stat.div_done;
      end
      ST_BATCH: begin
        cmd.div_sel   = DIV_BATCH;
        cmd.batch_add = stat.batch_add_ok;
        cmd.div_start = !stat.batch_add_ok && stat.batch_report;
      end
      ST_BATCH_WAIT: begin
        cmd.batch_ld = stat.div_done;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ccd_laser_spot_centroid.sv =====
// Top level of the linear-CCD laser spot centroid block.
// Pixels enter on in_* one item per cycle while the block is loading, in_tlast marking the last pixel of a frame.
// Each frame is stored in an on-chip frame memory while the window sum is accumulated.
// After the last pixel the block divides for the mean, scans the stored frame at one pixel
// per cycle, divides for the centroid (skipped, with the centroid cleared, when no pixel
// is dark) and, when a batch report is due, divides the scaled batch sum. An emit step
// then places the result item on out_*.
// All of a frame's work runs in one shared serial divider and one memory read port, and
// it ends before the next frame loads.
// The result sits in an output register; the next frame loads while it waits.
// If the receiver stalls longer than the next frame's work, the block holds in its
// final step until the register is free.
// cfg_* writes a register by index and is always ready; write only while idle.
// Synchronous active-low reset restores the register defaults, empties the batch and
// restarts the frame; the frame memory is not cleared.
module ccd_laser_spot_centroid import ccd_pkg::*; #(
  parameter int FRAME_PIXELS = 3694,
  parameter int MAX_BATCH    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel_value
  input  logic                   in_tlast,   // frame_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] spot_found, [12:1] centroid_index, [20:13] frame_mean, [21] batch_ready,
  // [37:22] batch_value, [38] batch_saturated, [39] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ccd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccd_dp #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .MAX_BATCH    (MAX_BATCH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
